// File: rtl/lsnb_pkg.sv
// Shared constants, types and helpers of the lidar scan node binner.
package lsnb_pkg;

    localparam int NUM_BINS   = 360;
    localparam int NODE_CAP   = 720;
    localparam int NUM_BANKS  = 3;
    localparam int FIFO_DEPTH = 3;
    localparam int NODE_LEN   = 5;

    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int CNT_W   = $clog2(NUM_BINS + 1);
    localparam int PEND_W  = $clog2(NODE_CAP + 1);
    localparam int IDX_W   = 10;
    localparam int DIST_W  = 16;
    localparam int QUAL_W  = 6;
    localparam int MM_W    = 14;
    localparam int PC_W    = 9;
    localparam int CFG_W   = 9;
    localparam int PHASE_W = 3;
    localparam int FPTR_W  = 2;
    localparam int FCNT_W  = 2;

    localparam logic [CFG_W-1:0]   MIN_VALID_RST = 9'd50;
    localparam logic [PHASE_W-1:0] PHASE_LAST    = PHASE_W'(NODE_LEN - 1);
    localparam logic [PC_W-1:0]    PC_MAX        = '1;

    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_READ   = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef logic [1:0] bank_sel_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_q2;
        logic [QUAL_W-1:0] qual;
    } bin_entry_t;

    localparam int ENTRY_W = $bits(bin_entry_t);

    typedef struct packed {
        logic              at_last;
        logic              ok;
        logic              sync;
        logic [BIN_W-1:0]  bin;
        logic [DIST_W-1:0] dist_q2;
        logic [QUAL_W-1:0] qual;
    } node_evt_t;

    typedef struct packed {
        logic init_busy;
        logic clr_busy;
        logic pending_nz;
    } store_status_t;

    typedef struct packed {
        logic              kind;
        logic [PC_W-1:0]   point_count;
        logic              scan_valid;
        logic [MM_W-1:0]   dist_mm;
        logic [QUAL_W-1:0] qual;
    } result_t;

    function automatic bank_sel_t bank_next(input bank_sel_t sel);
        bank_sel_t r;
        r = (sel == bank_sel_t'(NUM_BANKS - 1)) ? '0 : sel + 2'd1;
        return r;
    endfunction

    function automatic bank_sel_t bank_prev(input bank_sel_t sel);
        bank_sel_t r;
        r = (sel == '0) ? bank_sel_t'(NUM_BANKS - 1) : sel - 2'd1;
        return r;
    endfunction

    function automatic logic [PC_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
        logic [PC_W-1:0] r;
        r = (32'(cnt) > 32'(PC_MAX)) ? PC_MAX : cnt[PC_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/lsnb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsnb_ram #(
    parameter int DEPTH = 360,
    parameter int WIDTH = 22
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lsnb_node_asm.sv
// Byte phase counter, node byte holding registers and node decode.
module lsnb_node_asm import lsnb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_take,
    input  logic [7:0] data_byte,
    output node_evt_t evt
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         bytes_reg [NODE_LEN-1];
    logic [15:0]        angle_word;
    logic [IDX_W-1:0]   raw_bin;
    logic [IDX_W-1:0]   wrapped_bin;

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_take)
        begin
            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && (phase_reg != PHASE_LAST))
        begin
            bytes_reg[phase_reg[1:0]] <= data_byte;
        end
    end

    // Angle word: whole degrees in bits 15..7, wrap once into the bin range.
    always_comb
    begin
        angle_word  = {bytes_reg[2], bytes_reg[1]};
        raw_bin     = IDX_W'(angle_word[15:7]);
        wrapped_bin = (raw_bin >= IDX_W'(NUM_BINS)) ? raw_bin - IDX_W'(NUM_BINS) : raw_bin;

        evt.at_last = (phase_reg == PHASE_LAST);
        evt.ok      = angle_word[0] && (bytes_reg[0][0] != bytes_reg[0][1]);
        evt.sync    = bytes_reg[0][0];
        evt.bin     = wrapped_bin[BIN_W-1:0];
        evt.dist_q2 = {data_byte, bytes_reg[3]};
        evt.qual    = bytes_reg[0][7:2];
    end

endmodule

// File: rtl/lsnb_bin_store.sv
// Three rotating bin banks: working, published and background clear.
module lsnb_bin_store import lsnb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              node_take,
    input  logic              complete,
    input  node_evt_t         evt,
    input  logic              rd_take,
    input  logic [BIN_W-1:0]  rd_addr,
    output store_status_t     status,
    output logic [CNT_W-1:0]  working_count,
    output bin_entry_t        rd_entry
);

    bank_sel_t work_sel_reg, work_sel_next;
    bank_sel_t pub_sel, clr_sel;
    bank_sel_t rd_bank_reg;

    logic             init_reg, init_next;
    logic             clr_busy_reg, clr_busy_next;
    logic [BIN_W-1:0] clr_addr_reg, clr_addr_next;

    logic [PEND_W-1:0] pending_reg, pending_next, pending_base;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              bin_go;

    logic              s1_valid_reg, s2_valid_reg;
    logic [BIN_W-1:0]  s1_bin_reg, s2_bin_reg;
    logic [DIST_W-1:0] s1_dist_reg, s2_dist_reg;
    logic [QUAL_W-1:0] s1_qual_reg, s2_qual_reg;

    bin_entry_t       old_entry, new_entry;
    logic             s2_write;

    logic             ram_we    [NUM_BANKS];
    logic [BIN_W-1:0] ram_waddr [NUM_BANKS];
    bin_entry_t       ram_wdata [NUM_BANKS];
    logic [BIN_W-1:0] ram_raddr [NUM_BANKS];
    bin_entry_t       ram_rdata [NUM_BANKS];

    assign pub_sel = bank_prev(work_sel_reg);
    assign clr_sel = bank_next(work_sel_reg);

    // Capacity and revolution bookkeeping at the node beat.
    always_comb
    begin
        pending_base  = complete ? '0 : pending_reg;
        bin_go        = node_take && (pending_base < PEND_W'(NODE_CAP));
        pending_next  = bin_go ? pending_base + PEND_W'(1) : pending_base;
        work_sel_next = complete ? bank_next(work_sel_reg) : work_sel_reg;
    end

    // Sweep the clear bank one entry a cycle; after reset sweep all banks.
    always_comb
    begin
        init_next     = init_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == BIN_W'(NUM_BINS - 1))
            begin
                clr_busy_next = 1'b0;
                init_next     = 1'b0;
                clr_addr_next = '0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + BIN_W'(1);
            end
        end
        if (complete)
        begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end
    end

    // Read-modify-write of the working bin: nodes are at least five beats
    // apart, so a write always lands before the next read of any entry.
    always_comb
    begin
        old_entry         = ram_rdata[work_sel_reg];
        new_entry.dist_q2 = s2_dist_reg;
        new_entry.qual    = s2_qual_reg;
        s2_write          = s2_valid_reg &&
                            ((old_entry.dist_q2 == '0) || (s2_qual_reg > old_entry.qual));
        count_next        = count_reg;
        if (complete)
        begin
            count_next = '0;
        end
        else if (s2_write)
        begin
            if ((old_entry.dist_q2 == '0) && (s2_dist_reg != '0))
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if ((old_entry.dist_q2 != '0) && (s2_dist_reg == '0) && (count_reg != '0))
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            ram_raddr[b] = (bank_sel_t'(b) == pub_sel) ? rd_addr : s1_bin_reg;
            ram_we[b]    = 1'b0;
            ram_waddr[b] = clr_addr_reg;
            ram_wdata[b] = '0;
            if (init_reg || (clr_busy_reg && (bank_sel_t'(b) == clr_sel)))
            begin
                ram_we[b] = 1'b1;
            end
            else if (s2_write && (bank_sel_t'(b) == work_sel_reg))
            begin
                ram_we[b]    = 1'b1;
                ram_waddr[b] = s2_bin_reg;
                ram_wdata[b] = new_entry;
            end
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        lsnb_ram #(
            .DEPTH (NUM_BINS),
            .WIDTH (ENTRY_W)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .raddr (ram_raddr[g]),
            .rdata (ram_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_sel_reg <= '0;
            init_reg     <= 1'b1;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            pending_reg  <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            work_sel_reg <= work_sel_next;
            init_reg     <= init_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            pending_reg  <= pending_next;
            count_reg    <= count_next;
            s1_valid_reg <= bin_go;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_take)
        begin
            s1_bin_reg  <= evt.bin;
            s1_dist_reg <= evt.dist_q2;
            s1_qual_reg <= evt.qual;
        end
        s2_bin_reg  <= s1_bin_reg;
        s2_dist_reg <= s1_dist_reg;
        s2_qual_reg <= s1_qual_reg;
        if (rd_take)
        begin
            rd_bank_reg <= pub_sel;
        end
    end

    assign rd_entry          = ram_rdata[rd_bank_reg];
    assign working_count     = count_reg;
    assign status.init_busy  = init_reg;
    assign status.clr_busy   = clr_busy_reg;
    assign status.pending_nz = (pending_reg != '0);

endmodule

// File: rtl/lsnb_out_fifo.sv
// Three-entry result queue in front of the output channel.
module lsnb_out_fifo import lsnb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           push_data,
    input  logic              out_ready,
    output logic              out_valid,
    output result_t           head,
    output logic [FCNT_W-1:0] count
);

    result_t           entries [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] count_reg, count_next;
    logic              pop;

    function automatic logic [FPTR_W-1:0] ptr_inc(input logic [FPTR_W-1:0] p);
        logic [FPTR_W-1:0] r;
        r = (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FPTR_W'(1);
        return r;
    endfunction

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + FCNT_W'(push) - FCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entries[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/lidar_scan_node_binner.sv
// Top level of the lidar scan node binner: handshakes, result stage, config.
//
// Input channel (in_valid/in_ready): one beat per item. mode 0 carries one
// stream byte in data_byte; every fifth byte closes a 5-byte node, which is
// checked and binned by a read-modify-write of one angle bin. mode 1 reads
// one published bin at bin_index (out of range reads as zero).
// Output channel (out_valid/out_ready): kind 0 is the report of a completed
// revolution (point_count, scan_valid), kind 1 is a bin read reply.
// A result passes through the result stage and then the output queue.
// Throughput: one item per cycle while in_ready is high. The bins live in
// three RAM banks that rotate at each revolution: working, published, and
// one cleared in the background at one entry per cycle. A node that would
// complete a revolution waits while that sweep is still running.
// Reset: all three banks are swept to zero with in_ready low; cfg writes
// are taken during that time. min_valid_points resets to 50.
// Stall: results queue in a three-entry buffer; in_ready drops once that
// buffer and the result stage together hold three results, so no result
// is ever lost.
// cfg_we writes min_valid_points at once; write it only while idle.
module lidar_scan_node_binner import lsnb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [7:0]        data_byte,
    input  logic [8:0]        bin_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [PC_W-1:0]   point_count,
    output logic              scan_valid,
    output logic [MM_W-1:0]   bin_distance_mm,
    output logic [QUAL_W-1:0] bin_quality
);

    logic [CFG_W-1:0] min_valid_reg;

    node_evt_t         evt;
    store_status_t     status;
    logic [CNT_W-1:0]  working_count;
    bin_entry_t        rd_entry;
    logic [FCNT_W-1:0] fifo_count;
    result_t           push_data;
    result_t           head;

    logic accept, byte_take, node_take, rd_take, complete_cond, complete;
    logic space_ok;
    logic rd_oob;

    // Result stage: holds the beat while the registered bank read completes.
    logic             a_valid_reg;
    logic             a_kind_reg;
    logic [PC_W-1:0]  a_count_reg;
    logic             a_scan_reg;
    logic             a_oob_reg;

    // Room for this beat's result plus the one already in the result stage.
    assign space_ok = ({1'b0, fifo_count} + {2'b00, a_valid_reg}) <= 3'(FIFO_DEPTH - 1);

    assign complete_cond = evt.at_last && evt.ok && evt.sync && status.pending_nz;

    // Hold a revolution-completing node while the next bank is still clearing.
    assign in_ready = !status.init_busy && space_ok &&
                      !((mode == MODE_BYTE) && complete_cond && status.clr_busy);

    assign accept    = in_valid && in_ready;
    assign byte_take = accept && (mode == MODE_BYTE);
    assign node_take = byte_take && evt.at_last && evt.ok;
    assign complete  = byte_take && complete_cond;
    assign rd_take   = accept && (mode == MODE_READ);
    assign rd_oob    = ({1'b0, bin_index} >= IDX_W'(NUM_BINS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg <= MIN_VALID_RST;
        end
        else if (cfg_we)
        begin
            min_valid_reg <= cfg_wdata;
        end
    end

    lsnb_node_asm u_node_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .data_byte (data_byte),
        .evt       (evt)
    );

    lsnb_bin_store u_bin_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .node_take     (node_take),
        .complete      (complete),
        .evt           (evt),
        .rd_take       (rd_take),
        .rd_addr       (bin_index[BIN_W-1:0]),
        .status        (status),
        .working_count (working_count),
        .rd_entry      (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= rd_take || complete;
        end
    end

    // Capture the report before the revolution counters clear.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg  <= rd_take ? KIND_READ : KIND_REPORT;
            a_count_reg <= sat_count(working_count);
            a_scan_reg  <= (32'(working_count) > 32'(min_valid_reg));
            a_oob_reg   <= rd_oob;
        end
    end

    always_comb
    begin
        push_data.kind        = a_kind_reg;
        push_data.point_count = '0;
        push_data.scan_valid  = 1'b0;
        push_data.dist_mm     = '0;
        push_data.qual        = '0;
        if (a_kind_reg == KIND_REPORT)
        begin
            push_data.point_count = a_count_reg;
            push_data.scan_valid  = a_scan_reg;
        end
        else if (!a_oob_reg)
        begin
            push_data.dist_mm = rd_entry.dist_q2[DIST_W-1:2];
            push_data.qual    = rd_entry.qual;
        end
    end

    lsnb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (a_valid_reg),
        .push_data (push_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign kind            = head.kind;
    assign point_count     = head.point_count;
    assign scan_valid      = head.scan_valid;
    assign bin_distance_mm = head.dist_mm;
    assign bin_quality     = head.qual;

endmodule

// File: tb/lidar_scan_node_binner_tb.sv
// Self-checking testbench for the lidar scan node binner: directed and random beats.
module lidar_scan_node_binner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsnb_pkg::*;

    // DUT ports
    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic              mode;
    logic [7:0]        data_byte;
    logic [8:0]        bin_index;
    logic              out_valid;
    logic              out_ready;
    logic              kind;
    logic [PC_W-1:0]   point_count;
    logic              scan_valid;
    logic [MM_W-1:0]   bin_distance_mm;
    logic [QUAL_W-1:0] bin_quality;

    lidar_scan_node_binner dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .data_byte       (data_byte),
        .bin_index       (bin_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .point_count     (point_count),
        .scan_valid      (scan_valid),
        .bin_distance_mm (bin_distance_mm),
        .bin_quality     (bin_quality)
    );

    // Shadow copy of the binner: byte assembly, working and published bins,
    // points taken this revolution, filled-bin count and the threshold.
    logic [PHASE_W-1:0] phase_m;
    logic [7:0]         node_buf [PHASE_LAST];
    logic [DIST_W-1:0]  scan_dist [NUM_BINS];
    logic [QUAL_W-1:0]  scan_qual [NUM_BINS];
    logic [DIST_W-1:0]  pub_dist [NUM_BINS];
    logic [QUAL_W-1:0]  pub_qual [NUM_BINS];
    int unsigned        pend_m;
    int unsigned        filled_m;
    logic [CFG_W-1:0]   threshold_m;

    // Replies the block owes us, oldest first.
    result_t replies_due [$];

    // Idling knobs (percent chance per beat / per cycle) and read mix.
    int send_gap_pct;
    int stall_pct;
    int read_mix;

    // Bookkeeping for the summary.
    int unsigned beats_sent;
    int unsigned n_binned;
    int unsigned n_dropped;
    int unsigned n_capped;
    int unsigned n_reports;
    int unsigned n_reads;
    int unsigned errors;

    // Clock: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run, including the reset sweep
    // and the background bank clears at every revolution.
    initial
    begin
        #30_000_000;
        $display("Timeout with %0d replies still due", replies_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Read index: mostly real bins, sometimes past the end of the table.
    function automatic logic [8:0] pick_index();
        return ($urandom_range(0, 99) < 80) ? 9'($urandom_range(0, NUM_BINS - 1))
                                            : 9'($urandom_range(0, 511));
    endfunction

    // Advance the shadow binner by one accepted beat; queue any reply it owes.
    function automatic void apply_beat(input logic m, input logic [7:0] b,
                                       input logic [8:0] idx);
        result_t           r;
        logic [15:0]       aw;
        logic [DIST_W-1:0] d;
        logic [QUAL_W-1:0] q;
        logic              s;
        logic              inv;
        int                bn;
        r = '0;
        if (m == MODE_READ)
        begin
            // Bin read: out-of-range indexes read as zero.
            r.kind = KIND_READ;
            if (idx < NUM_BINS)
            begin
                r.dist_mm = pub_dist[idx][DIST_W-1:2];
                r.qual    = pub_qual[idx];
            end
            replies_due.push_back(r);
            n_reads++;
            return;
        end
        // Hold the first four bytes; the fifth closes the node.
        if (phase_m < PHASE_LAST)
        begin
            node_buf[phase_m] = b;
            phase_m++;
            return;
        end
        phase_m = '0;
        aw  = {node_buf[2], node_buf[1]};
        d   = {b, node_buf[3]};
        s   = node_buf[0][0];
        inv = node_buf[0][1];
        q   = node_buf[0][7:2];
        // Drop nodes with a clear check bit or a start flag equal to its inverse.
        if (!aw[0] || s == inv)
        begin
            n_dropped++;
            return;
        end
        // A start node with points pending closes the revolution first.
        if (s && pend_m > 0)
        begin
            r.kind        = KIND_REPORT;
            r.point_count = (filled_m > 511) ? PC_MAX : PC_W'(filled_m);
            r.scan_valid  = (filled_m > threshold_m);
            replies_due.push_back(r);
            pub_dist  = scan_dist;
            pub_qual  = scan_qual;
            scan_dist = '{default: '0};
            scan_qual = '{default: '0};
            pend_m    = 0;
            filled_m  = 0;
            n_reports++;
        end
        // Past the per-revolution cap, drop points until the next start.
        if (pend_m < NODE_CAP)
        begin
            pend_m++;
            bn = (aw >> 7) % NUM_BINS;
            // Take the point into an empty bin or on strictly better quality,
            // even when the point itself carries a zero distance.
            if (scan_dist[bn] == '0 || q > scan_qual[bn])
            begin
                if (scan_dist[bn] == '0 && d != '0)
                    filled_m++;
                else if (scan_dist[bn] != '0 && d == '0 && filled_m > 0)
                    filled_m--;
                scan_dist[bn] = d;
                scan_qual[bn] = q;
            end
            n_binned++;
        end
        else
            n_capped++;
    endfunction

    // Send one beat: raise valid with the payload, hold until accepted, then
    // maybe idle. Valid is left high when no gap follows.
    task automatic send_beat(input logic m, input logic [7:0] b, input logic [8:0] idx);
        int gap;
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= b;
        bin_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        apply_beat(m, b, idx);
        beats_sent++;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send one 5-byte node, with bin reads slipped in between its bytes.
    task automatic send_node(input logic [5:0] q, input logic sync, input logic inv,
                             input logic chk, input logic [8:0] deg,
                             input logic [15:0] range_q2);
        logic [7:0]  nb [NODE_LEN];
        logic [15:0] word;
        int          k;
        word = {deg, 6'($urandom), chk};
        nb   = '{{q, inv, sync}, word[7:0], word[15:8], range_q2[7:0], range_q2[15:8]};
        for (k = 0; k < NODE_LEN; k++)
        begin
            if (read_mix != 0 && $urandom_range(0, 99) < read_mix)
                send_beat(MODE_READ, 8'($urandom), pick_index());
            send_beat(MODE_BYTE, nb[k], 9'($urandom));
        end
    endtask

    // Drop valid, wait for every due reply and let the pipe drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write min_valid_points while the block is idle.
    task automatic write_threshold(input logic [CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        threshold_m = v;
    endtask

    // Published bins are all zero after reset, in range or not.
    task automatic test_reset_state();
        send_beat(MODE_READ, 8'h00, 9'd0);
        send_beat(MODE_READ, 8'hFF, 9'(NUM_BINS - 1));
        send_beat(MODE_READ, 8'h00, 9'(NUM_BINS));
        send_beat(MODE_READ, 8'hFF, 9'd511);
    endtask

    // Start with nothing pending, the two drop rules and the angle wrap.
    task automatic test_node_filters();
        // Start flag on an empty revolution: no report, just a first point.
        send_node(6'd63, 1'b1, 1'b0, 1'b1, 9'd5, 16'hFFFF);
        // Check bit clear.
        send_node(6'd10, 1'b0, 1'b1, 1'b0, 9'd6, 16'd100);
        // Start flag equal to its inverse, both ways.
        send_node(6'd10, 1'b0, 1'b0, 1'b1, 9'd7, 16'd100);
        send_node(6'd10, 1'b1, 1'b1, 1'b1, 9'd8, 16'd100);
        // Top angle word wraps into bin 151.
        send_node(6'd0, 1'b0, 1'b1, 1'b1, 9'd511, 16'd4);
    endtask

    // Bin replacement by quality, zero-distance points, report and reads.
    task automatic test_bin_choice();
        // Lower quality into a taken bin: keep the old point.
        send_node(6'd62, 1'b0, 1'b1, 1'b1, 9'd5, 16'd1000);
        // Higher quality with zero distance empties the bin; an empty bin
        // then takes any point, here one that truncates to 0 mm.
        send_node(6'd20, 1'b0, 1'b1, 1'b1, 9'd9, 16'd800);
        send_node(6'd30, 1'b0, 1'b1, 1'b1, 9'd9, 16'd0);
        send_node(6'd5, 1'b0, 1'b1, 1'b1, 9'd9, 16'd3);
        // Close the revolution at the default threshold.
        send_node(6'd1, 1'b1, 1'b0, 1'b1, 9'd100, 16'h1234);
        send_beat(MODE_READ, 8'h00, 9'd5);
        send_beat(MODE_READ, 8'h00, 9'd151);
        send_beat(MODE_READ, 8'h00, 9'd9);
        send_beat(MODE_READ, 8'h00, 9'd100);
        send_beat(MODE_READ, 8'h00, 9'd6);
    endtask

    // Threshold zero: a single filled bin already makes the scan valid.
    task automatic test_threshold_zero();
        write_threshold('0);
        send_node(6'd33, 1'b1, 1'b0, 1'b1, 9'd200, 16'd4000);
    endtask

    // Fill one revolution to the point cap, then push more points into
    // fresh bins: they must not show up in the count or the published bins.
    task automatic test_capacity();
        int i;
        write_threshold(9'd179);
        send_gap_pct = 5;
        stall_pct    = 5;
        send_node(6'($urandom), 1'b1, 1'b0, 1'b1, 9'd0, 16'($urandom_range(1, 65535)));
        for (i = 1; i < NODE_CAP; i++)
            send_node(6'($urandom), 1'b0, 1'b1, 1'b1, 9'(i % 180),
                      16'($urandom_range(1, 65535)));
        for (i = 0; i < 10; i++)
            send_node(6'd63, 1'b0, 1'b1, 1'b1, 9'(200 + i), 16'($urandom_range(1, 65535)));
        send_node(6'd7, 1'b1, 1'b0, 1'b1, 9'd300, 16'd500);
        send_beat(MODE_READ, 8'h00, 9'd200);
        send_beat(MODE_READ, 8'h00, 9'd209);
        send_beat(MODE_READ, 8'h00, 9'd0);
        send_beat(MODE_READ, 8'h00, 9'd179);
    endtask

    // One node of a random revolution: sometimes preceded by stray bytes,
    // always realigned, occasionally malformed.
    task automatic random_node(input logic starts, input int pool);
        logic [8:0]  deg;
        logic [15:0] range_q2;
        logic        s;
        logic        inv;
        logic        chk;
        int          roll;
        if ($urandom_range(0, 99) < 4)
            repeat ($urandom_range(1, 4)) send_beat(MODE_BYTE, 8'($urandom), 9'($urandom));
        while (phase_m != '0)
            send_beat(MODE_BYTE, 8'($urandom), 9'($urandom));
        deg      = (pool == 0) ? 9'($urandom) : 9'($urandom_range(0, pool - 1));
        range_q2 = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        s        = starts;
        inv      = ~starts;
        chk      = 1'b1;
        roll     = $urandom_range(0, 99);
        if (!starts && roll < 3)
            chk = 1'b0;
        else if (!starts && roll < 6)
        begin
            s   = 1'(roll);
            inv = s;
        end
        send_node(6'($urandom), s, inv, chk, deg, range_q2);
    endtask

    // Random revolutions of random length over narrow or wide angle spreads,
    // across several thresholds and idling mixes.
    task automatic test_random_stream();
        logic [CFG_W-1:0] thr_list [5];
        int unsigned      goal;
        int               ph;
        int               n;
        int               nodes;
        int               pool;
        thr_list = '{9'd360, 9'd511, 9'd0, 9'd25, 9'($urandom_range(1, 60))};
        read_mix = 15;
        for (ph = 0; ph < 5; ph++)
        begin
            write_threshold(thr_list[ph]);
            case (ph)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 30; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 30; end
                default: begin send_gap_pct = 25; stall_pct = 25; end
            endcase
            goal = beats_sent + 390;
            while (beats_sent < goal)
            begin
                nodes = $urandom_range(3, 90);
                case ($urandom_range(0, 2))
                    0:       pool = 12;
                    1:       pool = 60;
                    default: pool = 0;
                endcase
                for (n = 0; n < nodes && beats_sent < goal; n++)
                    random_node(n == 0, pool);
            end
        end
    endtask

    // Output side: ready with random stalls, none when stall_pct is zero.
    initial
    begin : out_side
        int hold;
        out_ready = 1'b0;
        hold      = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                    hold = pick_gap();
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare every reply beat against the oldest one due.
    always @(posedge clk)
    begin : reply_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply beat with none due, kind %0d", $time, kind);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("kind", want.kind, kind);
                check_field("point_count", want.point_count, point_count);
                check_field("scan_valid", want.scan_valid, scan_valid);
                check_field("bin_distance_mm", want.dist_mm, bin_distance_mm);
                check_field("bin_quality", want.qual, bin_quality);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        mode         = MODE_BYTE;
        data_byte    = '0;
        bin_index    = '0;
        send_gap_pct = 0;
        stall_pct    = 0;
        read_mix     = 0;
        beats_sent   = 0;
        n_binned     = 0;
        n_dropped    = 0;
        n_capped     = 0;
        n_reports    = 0;
        n_reads      = 0;
        errors       = 0;
        phase_m      = '0;
        node_buf     = '{default: '0};
        scan_dist    = '{default: '0};
        scan_qual    = '{default: '0};
        pub_dist     = '{default: '0};
        pub_qual     = '{default: '0};
        pend_m       = 0;
        filled_m     = 0;
        threshold_m  = MIN_VALID_RST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_node_filters();
        test_bin_choice();
        test_threshold_zero();
        test_capacity();
        test_random_stream();

        // Drain: every reply in, then a few spare cycles to catch extras.
        settle();
        repeat (20) @(posedge clk);

        $display("Covered %0d beats: %0d bin reads, %0d revolution reports,", beats_sent,
                 n_reads, n_reports);
        $display("%0d points binned, %0d malformed nodes dropped, %0d over the cap.",
                 n_binned, n_dropped, n_capped);
        if (errors == 0 && replies_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
